[src/lcdseq_pkg.sv]
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, op codes and the microcode table for the character-LCD
// nibble frame sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	localparam int OP_W      = 3;
	localparam int CHAR_W    = 8;
	localparam int COL_W     = 6;
	localparam int NIB_W     = 4;
	localparam int FRAME_W   = 8;
	localparam int WAIT_W    = 6;
	localparam int UCODE_LEN = 42;
	localparam int PC_W      = $clog2(UCODE_LEN);

	// request op codes
	localparam logic [OP_W-1:0] OP_WRITE_CHAR    = 3'd0;
	localparam logic [OP_W-1:0] OP_GOTO          = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR         = 3'd2;
	localparam logic [OP_W-1:0] OP_INIT          = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_BACKLIGHT = 3'd4;

	// program entry points
	localparam logic [PC_W-1:0] PC_WRITE_CHAR    = 6'd0;
	localparam logic [PC_W-1:0] PC_GOTO          = 6'd4;
	localparam logic [PC_W-1:0] PC_CLEAR         = 6'd8;
	localparam logic [PC_W-1:0] PC_INIT          = 6'd12;
	localparam logic [PC_W-1:0] PC_SET_BACKLIGHT = 6'd41;

	// wait times in ms
	localparam logic [WAIT_W-1:0] W0  = 6'd0;
	localparam logic [WAIT_W-1:0] W2  = 6'd2;
	localparam logic [WAIT_W-1:0] W4  = 6'd4;
	localparam logic [WAIT_W-1:0] W20 = 6'd20;
	localparam logic [WAIT_W-1:0] W42 = 6'd42;

	// where the nibble of a frame comes from
	typedef enum logic [2:0] {
		NS_CONST,
		NS_CHAR_HI,
		NS_CHAR_LO,
		NS_ADDR_HI,
		NS_ADDR_LO,
		NS_MODE
	} nib_sel_t;

	// one control word per frame
	typedef struct packed {
		nib_sel_t          sel;
		logic [NIB_W-1:0]  konst;
		logic              e;
		logic              rs;
		logic [WAIT_W-1:0] wait_ms;
		logic              last;
	} ucode_t;

	function automatic ucode_t uw(nib_sel_t sel, logic [NIB_W-1:0] konst, logic e,
			logic rs, logic [WAIT_W-1:0] wait_ms, logic last);
		ucode_t u;
		u.sel     = sel;
		u.konst   = konst;
		u.e       = e;
		u.rs      = rs;
		u.wait_ms = wait_ms;
		u.last    = last;
		return u;
	endfunction

	// microcode rom
	function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
		ucode_t u;
		unique case (pc)
			// write char: data nibbles, high then low
			6'd0:  u = uw(NS_CHAR_HI, 4'h0, 1'b1, 1'b1, W0,  1'b0);
			6'd1:  u = uw(NS_CHAR_HI, 4'h0, 1'b0, 1'b1, W0,  1'b0);
			6'd2:  u = uw(NS_CHAR_LO, 4'h0, 1'b1, 1'b1, W0,  1'b0);
			6'd3:  u = uw(NS_CHAR_LO, 4'h0, 1'b0, 1'b1, W0,  1'b1);
			// goto
			6'd4:  u = uw(NS_ADDR_HI, 4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd5:  u = uw(NS_ADDR_HI, 4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd6:  u = uw(NS_ADDR_LO, 4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd7:  u = uw(NS_ADDR_LO, 4'h0, 1'b0, 1'b0, W4,  1'b1);
			// clear
			6'd8:  u = uw(NS_CONST,   4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd9:  u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd10: u = uw(NS_CONST,   4'h1, 1'b1, 1'b0, W0,  1'b0);
			6'd11: u = uw(NS_CONST,   4'h1, 1'b0, 1'b0, W4,  1'b1);
			// init: idle frame, then the 8-bit to 4-bit wake-up
			6'd12: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W20, 1'b0);
			6'd13: u = uw(NS_CONST,   4'h3, 1'b1, 1'b0, W0,  1'b0);
			6'd14: u = uw(NS_CONST,   4'h3, 1'b0, 1'b0, W42, 1'b0);
			6'd15: u = uw(NS_CONST,   4'h3, 1'b1, 1'b0, W0,  1'b0);
			6'd16: u = uw(NS_CONST,   4'h3, 1'b0, 1'b0, W42, 1'b0);
			6'd17: u = uw(NS_CONST,   4'h3, 1'b1, 1'b0, W0,  1'b0);
			6'd18: u = uw(NS_CONST,   4'h3, 1'b0, 1'b0, W42, 1'b0);
			6'd19: u = uw(NS_CONST,   4'h2, 1'b1, 1'b0, W0,  1'b0);
			6'd20: u = uw(NS_CONST,   4'h2, 1'b0, 1'b0, W42, 1'b0);
			// function set 0x28
			6'd21: u = uw(NS_CONST,   4'h2, 1'b1, 1'b0, W0,  1'b0);
			6'd22: u = uw(NS_CONST,   4'h2, 1'b0, 1'b0, W2,  1'b0);
			6'd23: u = uw(NS_CONST,   4'h8, 1'b1, 1'b0, W0,  1'b0);
			6'd24: u = uw(NS_CONST,   4'h8, 1'b0, 1'b0, W2,  1'b0);
			// display off 0x08
			6'd25: u = uw(NS_CONST,   4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd26: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd27: u = uw(NS_CONST,   4'h8, 1'b1, 1'b0, W0,  1'b0);
			6'd28: u = uw(NS_CONST,   4'h8, 1'b0, 1'b0, W2,  1'b0);
			// clear 0x01
			6'd29: u = uw(NS_CONST,   4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd30: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd31: u = uw(NS_CONST,   4'h1, 1'b1, 1'b0, W0,  1'b0);
			6'd32: u = uw(NS_CONST,   4'h1, 1'b0, 1'b0, W2,  1'b0);
			// entry mode 0x06
			6'd33: u = uw(NS_CONST,   4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd34: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd35: u = uw(NS_CONST,   4'h6, 1'b1, 1'b0, W0,  1'b0);
			6'd36: u = uw(NS_CONST,   4'h6, 1'b0, 1'b0, W2,  1'b0);
			// display control 0x0 then mode
			6'd37: u = uw(NS_CONST,   4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd38: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W2,  1'b0);
			6'd39: u = uw(NS_MODE,    4'h0, 1'b1, 1'b0, W0,  1'b0);
			6'd40: u = uw(NS_MODE,    4'h0, 1'b0, 1'b0, W2,  1'b1);
			// set backlight: one idle frame
			6'd41: u = uw(NS_CONST,   4'h0, 1'b0, 1'b0, W0,  1'b1);
			default: u = uw(NS_CONST, 4'h0, 1'b0, 1'b0, W0,  1'b1);
		endcase
		return u;
	endfunction

endpackage

[src/lcdseq_if.sv]
// ----------------------------------------------------------------------------
// lcdseq_req_if / lcdseq_rsp_if
// Valid/ready channels for requests and frames of the LCD frame sequencer.
// ----------------------------------------------------------------------------
interface lcdseq_req_if import lcdseq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] char_code;
	logic [COL_W-1:0]  column;
	logic              row;
	logic              backlight_on;
	logic [NIB_W-1:0]  init_mode;

	modport source (output valid, op, char_code, column, row, backlight_on, init_mode,
		input ready);
	modport sink (input valid, op, char_code, column, row, backlight_on, init_mode,
		output ready);
endinterface

interface lcdseq_rsp_if import lcdseq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame;
	logic [WAIT_W-1:0]  wait_ms;
	logic               last;

	modport source (output valid, frame, wait_ms, last, input ready);
	modport sink (input valid, frame, wait_ms, last, output ready);
endinterface

[src/char_lcd_nibble_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_frame_sequencer
// Turns character-LCD requests into shift-register frames for a 4-bit
// display bus behind an 8-bit serial-in latch.
// ----------------------------------------------------------------------------
// Each accepted request item runs a short microcode program, one control word
// per frame, and each frame leaves through a registered output item carrying
// the frame byte (RS bit 0, RW bit 1 = 0, E bit 2, nibble bits 3-6, backlight
// bit 7), the wait in ms to hold after latching it, and a last flag on the
// final frame. Frame counts: write char 4, goto 4, clear 4, init 29, set
// backlight 1; op codes 5 to 7 are taken and dropped with no frame. The step
// counter advances one control word per cycle while the sink takes frames;
// sink stalls hold it. A new request is taken once the last frame has moved
// into the output register, even while that frame still waits for the sink.
// The backlight level resets to off and is placed into every frame.
module char_lcd_nibble_frame_sequencer
	import lcdseq_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lcdseq_req_if.sink    req,
	lcdseq_rsp_if.source  rsp
);

	// sequencer control
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            backlight_q;

	// request fields held for the running program
	logic [CHAR_W-1:0] char_q;
	logic [COL_W-1:0]  col_q;
	logic              row_q;
	logic [NIB_W-1:0]  mode_q;

	// output register
	logic               rsp_valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic [WAIT_W-1:0]  wait_q;
	logic               last_q;

	ucode_t            uc;
	logic [CHAR_W-1:0] addr;
	logic [NIB_W-1:0]  mode_nib;
	logic [NIB_W-1:0]  nib;
	logic              req_fire;
	logic              step;
	logic              start;
	logic [PC_W-1:0]   start_pc;

	assign req.ready = !busy_q;
	assign req_fire  = req.valid && req.ready;
	assign step      = busy_q && (!rsp_valid_q || rsp.ready);

	assign rsp.valid   = rsp_valid_q;
	assign rsp.frame   = frame_q;
	assign rsp.wait_ms = wait_q;
	assign rsp.last    = last_q;

	// program dispatch by op code
	always_comb begin
		start    = 1'b1;
		start_pc = PC_WRITE_CHAR;
		unique case (req.op)
			OP_WRITE_CHAR:    start_pc = PC_WRITE_CHAR;
			OP_GOTO:          start_pc = PC_GOTO;
			OP_CLEAR:         start_pc = PC_CLEAR;
			OP_INIT:          start_pc = PC_INIT;
			OP_SET_BACKLIGHT: start_pc = PC_SET_BACKLIGHT;
			default:          start    = 1'b0;
		endcase
	end

	// control word fetch and nibble datapath
	assign uc = ucode_rom(pc_q);

	// ddram address 0x80 + column + row*0x40, column below 64 so no carry
	assign addr = {1'b1, row_q, col_q};

	// modes 0..3 stand for 0xC..0xF
	assign mode_nib = (mode_q[3:2] == 2'b00) ? {2'b11, mode_q[1:0]} : mode_q;

	always_comb begin
		unique case (uc.sel)
			NS_CONST:   nib = uc.konst;
			NS_CHAR_HI: nib = char_q[7:4];
			NS_CHAR_LO: nib = char_q[3:0];
			NS_ADDR_HI: nib = addr[7:4];
			NS_ADDR_LO: nib = addr[3:0];
			NS_MODE:    nib = mode_nib;
			default:    nib = uc.konst;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			backlight_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new frame refills the register, else the sink empties it
			if (step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_fire) begin
				busy_q <= start;
				pc_q   <= start_pc;
				if (req.op == OP_SET_BACKLIGHT) begin
					backlight_q <= req.backlight_on;
				end
			end else if (step) begin
				pc_q <= pc_q + 1'b1;
				if (uc.last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			char_q <= req.char_code;
			col_q  <= req.column;
			row_q  <= req.row;
			mode_q <= req.init_mode;
		end
		if (step) begin
			frame_q <= {backlight_q, nib, uc.e, 1'b0, uc.rs};
			wait_q  <= uc.wait_ms;
			last_q  <= uc.last;
		end
	end

endmodule

[tb/sv/char_lcd_nibble_frame_sequencer_test.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_frame_sequencer_test
// Self-checking bench for the LCD frame sequencer. Request items are driven
// with random gaps while the frame sink stalls at random. Every accepted
// request is expanded into its expected frames by a predictor that tracks the
// stored backlight level. Each accepted frame is then compared, field by
// field, with the oldest frame still expected.
// ----------------------------------------------------------------------------
module char_lcd_nibble_frame_sequencer_test import lcdseq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// generous cap: every item at 29 frames, each frame behind a long stall
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 120;
	// wait for any stray frame after the last one we expect
	localparam int TAIL_CYCLES  = 64;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  column;
		logic              row;
		logic              backlight_on;
		logic [NIB_W-1:0]  init_mode;
	} lcd_request_t;

	typedef struct {
		logic [FRAME_W-1:0] frame;
		logic [WAIT_W-1:0]  wait_ms;
		logic               last;
	} lcd_frame_t;

	// predicts the frame stream and matches it against what the block sends
	class lcd_frame_board;
		lcd_frame_t expected_frames[$];
		logic       backlight;
		int         errors;

		function new();
			backlight = 1'b0;
			errors    = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// frame byte: backlight, nibble d7..d4, E, RW = 0, RS
		function void push_frame(logic [NIB_W-1:0] nib, logic e, logic rs,
				logic [WAIT_W-1:0] wait_ms);
			lcd_frame_t f;
			f.frame   = {backlight, nib, e, 1'b0, rs};
			f.wait_ms = wait_ms;
			f.last    = 1'b0;
			expected_frames.push_back(f);
		endfunction

		// E high with no wait, then E low with the settle time
		function void push_nibble(logic [NIB_W-1:0] nib, logic rs,
				logic [WAIT_W-1:0] wait_low);
			push_frame(nib, 1'b1, rs, W0);
			push_frame(nib, 1'b0, rs, wait_low);
		endfunction

		function void note_request(lcd_request_t r);
			logic [7:0]       addr;
			logic [NIB_W-1:0] mode;
			lcd_frame_t       tail;
			int               start;
			start = expected_frames.size();
			case (r.op)
				OP_WRITE_CHAR: begin
					push_nibble(r.char_code[7:4], 1'b1, W0);
					push_nibble(r.char_code[3:0], 1'b1, W0);
				end
				OP_GOTO: begin
					addr = 8'h80 | ({2'b00, r.column} + {1'b0, r.row, 6'd0});
					push_nibble(addr[7:4], 1'b0, W2);
					push_nibble(addr[3:0], 1'b0, W4);
				end
				OP_CLEAR: begin
					push_nibble(4'h0, 1'b0, W2);
					push_nibble(4'h1, 1'b0, W4);
				end
				OP_INIT: begin
					// modes 0..3 select the display-on variants, others go raw
					mode = (r.init_mode <= 4'd3) ? r.init_mode + 4'hC : r.init_mode;
					push_frame(4'h0, 1'b0, 1'b0, W20);
					push_nibble(4'h3, 1'b0, W42);
					push_nibble(4'h3, 1'b0, W42);
					push_nibble(4'h3, 1'b0, W42);
					push_nibble(4'h2, 1'b0, W42);
					push_nibble(4'h2, 1'b0, W2);
					push_nibble(4'h8, 1'b0, W2);
					push_nibble(4'h0, 1'b0, W2);
					push_nibble(4'h8, 1'b0, W2);
					push_nibble(4'h0, 1'b0, W2);
					push_nibble(4'h1, 1'b0, W2);
					push_nibble(4'h0, 1'b0, W2);
					push_nibble(4'h6, 1'b0, W2);
					push_nibble(4'h0, 1'b0, W2);
					push_nibble(mode, 1'b0, W2);
				end
				OP_SET_BACKLIGHT: begin
					// the new level already shows in the idle frame
					backlight = r.backlight_on;
					push_frame(4'h0, 1'b0, 1'b0, W0);
				end
				default: ;
			endcase
			if (expected_frames.size() > start) begin
				tail      = expected_frames.pop_back();
				tail.last = 1'b1;
				expected_frames.push_back(tail);
			end
		endfunction

		task check_frame(input lcd_frame_t got);
			lcd_frame_t want;
			if (expected_frames.size() == 0) begin
				report($sformatf("frame %02h wait %0d last %0b with none expected",
					got.frame, got.wait_ms, got.last));
				return;
			end
			want = expected_frames.pop_front();
			if (got.frame !== want.frame)
				report($sformatf("frame %02h, expected %02h", got.frame, want.frame));
			if (got.wait_ms !== want.wait_ms)
				report($sformatf("wait_ms %0d, expected %0d on frame %02h",
					got.wait_ms, want.wait_ms, want.frame));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b on frame %02h",
					got.last, want.last, want.frame));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	// when set, neither side inserts idle cycles
	bit   calm;

	lcdseq_req_if req ();
	lcdseq_rsp_if rsp ();

	lcd_frame_board board = new();

	char_lcd_nibble_frame_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// sampled at the edge, so both see the values the block acted on
	always @(posedge clk) begin
		lcd_frame_t   got;
		lcd_request_t seen;
		if (arst_n) begin
			// frames first: a request accepted now cannot emit at this edge
			if (rsp.valid && rsp.ready) begin
				got.frame   = rsp.frame;
				got.wait_ms = rsp.wait_ms;
				got.last    = rsp.last;
				board.check_frame(got);
			end
			if (req.valid && req.ready) begin
				seen.op           = req.op;
				seen.char_code    = req.char_code;
				seen.column       = req.column;
				seen.row          = req.row;
				seen.backlight_on = req.backlight_on;
				seen.init_mode    = req.init_mode;
				board.note_request(seen);
			end
		end
	end

	// frame sink: bursts of ready broken by random stalls
	initial begin
		int hold;
		int gap;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			hold = $urandom_range(1, 12);
			rsp.ready <= 1'b1;
			repeat (hold) @(posedge clk);
			gap = calm ? 0 : idle_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	function automatic lcd_request_t make_req(logic [OP_W-1:0] op,
			logic [CHAR_W-1:0] char_code, logic [COL_W-1:0] column, logic row,
			logic backlight_on, logic [NIB_W-1:0] init_mode);
		lcd_request_t r;
		r.op           = op;
		r.char_code    = char_code;
		r.column       = column;
		r.row          = row;
		r.backlight_on = backlight_on;
		r.init_mode    = init_mode;
		return r;
	endfunction

	// fields an op does not use are random too, the block must ignore them
	function automatic lcd_request_t random_req();
		lcd_request_t r;
		int           pick;
		r = make_req(OP_WRITE_CHAR, CHAR_W'($urandom_range(0, 255)),
			COL_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), NIB_W'($urandom_range(0, 15)));
		pick = $urandom_range(0, 99);
		if (pick < 28)
			r.op = OP_WRITE_CHAR;
		else if (pick < 50)
			r.op = OP_GOTO;
		else if (pick < 64)
			r.op = OP_CLEAR;
		else if (pick < 76)
			r.op = OP_INIT;
		else if (pick < 94)
			r.op = OP_SET_BACKLIGHT;
		else
			r.op = OP_W'($urandom_range(OP_SET_BACKLIGHT + 1, 7));
		return r;
	endfunction

	// called at a clock edge; returns after the item was taken and any idle gap that follows
	task automatic send_request(input lcd_request_t r);
		int gap;
		req.valid        <= 1'b1;
		req.op           <= r.op;
		req.char_code    <= r.char_code;
		req.column       <= r.column;
		req.row          <= r.row;
		req.backlight_on <= r.backlight_on;
		req.init_mode    <= r.init_mode;
		do @(posedge clk); while (!req.ready);
		// with no gap valid simply stays high for the next item
		gap = calm ? 0 : idle_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		lcd_request_t r;
		int           counted;
		calm             = 1'b0;
		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.op           <= OP_WRITE_CHAR;
		req.char_code    <= '0;
		req.column       <= '0;
		req.row          <= 1'b0;
		req.backlight_on <= 1'b0;
		req.init_mode    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every op, mode mapping edges, unused ops
		send_request(make_req(OP_WRITE_CHAR, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_WRITE_CHAR, 8'hFF, 6'd63, 1'b1, 1'b1, 4'd15));
		send_request(make_req(OP_GOTO, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));
		// top column on the second row gives address 0xFF
		send_request(make_req(OP_GOTO, 8'hFF, 6'd63, 1'b1, 1'b1, 4'd15));
		send_request(make_req(OP_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_SET_BACKLIGHT, 8'h00, 6'd0, 1'b0, 1'b1, 4'd0));
		// backlight now on in every frame
		send_request(make_req(OP_WRITE_CHAR, 8'hA5, 6'd0, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_GOTO, 8'h00, 6'd21, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd3));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd4));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd15));
		// unused op codes: taken, no frames, backlight kept
		send_request(make_req(OP_SET_BACKLIGHT + 3'd1, 8'hFF, 6'd63, 1'b1, 1'b0, 4'd15));
		send_request(make_req(OP_SET_BACKLIGHT + 3'd2, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));
		send_request(make_req(OP_SET_BACKLIGHT + 3'd3, 8'h5A, 6'd42, 1'b1, 1'b0, 4'd9));
		send_request(make_req(OP_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b0, 4'd15));
		send_request(make_req(OP_SET_BACKLIGHT, 8'hFF, 6'd63, 1'b1, 1'b0, 4'd15));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b1, 4'd1));
		send_request(make_req(OP_WRITE_CHAR, 8'h5A, 6'd0, 1'b0, 1'b1, 4'd0));
		send_request(make_req(OP_GOTO, 8'h00, 6'd42, 1'b1, 1'b1, 4'd2));
		send_request(make_req(OP_SET_BACKLIGHT, 8'h00, 6'd0, 1'b0, 1'b1, 4'd0));
		send_request(make_req(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd2));
		send_request(make_req(OP_SET_BACKLIGHT, 8'h00, 6'd0, 1'b0, 1'b0, 4'd0));

		// random part; ignored op codes do not count toward the total
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			// now and then a stretch where neither side idles
			if (counted % 20 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = random_req();
			if (r.op <= OP_SET_BACKLIGHT)
				counted++;
			send_request(r);
		end
		calm = 1'b0;
		req.valid <= 1'b0;
		// let the monitor note the last request before looking at the queue
		@(posedge clk);

		// drain, then give any stray frame time to show up
		while (board.expected_frames.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
